// File: design/spd_pkg.sv
`default_nettype none

package spd_pkg;

	// SLIP special characters.
	localparam logic [7:0] CHAR_END     = 8'hc0;
	localparam logic [7:0] CHAR_ESC     = 8'hdb;
	localparam logic [7:0] CHAR_ESC_END = 8'hdc;
	localparam logic [7:0] CHAR_ESC_ESC = 8'hdd;

	localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

	// Configuration register indexes.
	localparam logic CFG_FRAME_MODE = 1'b0;
	localparam logic CFG_MAX_LENGTH = 1'b1;

	// Framing modes.
	localparam logic MODE_LENGTH = 1'b0;
	localparam logic MODE_SLIP   = 1'b1;

	// Result queue depth; a byte can produce at most two results.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned LEVEL_W    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		PH_SYNC,
		PH_FRAME
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       fend;
		logic       lerr;
	} result_t;

	// Results produced by one stream byte.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	// Queue status seen by the framing stage.
	typedef struct packed {
		logic               room;
		logic [LEVEL_W-1:0] level;
	} fifo_status_t;

endpackage

`default_nettype wire

// File: design/spd_core.sv
`default_nettype none

module spd_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [7:0]            in_byte,
	output logic                       in_stall,
	input  wire logic                  room,
	input  wire logic                  frame_mode,
	input  wire logic [15:0]           max_length,
	input  wire logic                  clear,
	output spd_pkg::push_t             push
);

	logic            valid_s1;
	logic [7:0]      byte_s1;

	spd_pkg::phase_t phase_q, phase_d;
	logic [1:0]      hc_q, hc_d;
	logic [23:0]     acc_q, acc_d;
	logic [15:0]     rem_q, rem_d;
	logic            esc_q, esc_d;
	logic            nonempty_q, nonempty_d;

	logic            step;
	logic [31:0]     len;
	logic [15:0]     rem_dec;

	assign in_stall = valid_s1 && !room;
	assign step     = valid_s1 && room;
	assign len      = {acc_q, byte_s1};
	assign rem_dec  = rem_q - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= spd_pkg::PH_SYNC;
			hc_q       <= 2'd0;
			acc_q      <= 24'd0;
			rem_q      <= 16'd0;
			esc_q      <= 1'b0;
			nonempty_q <= 1'b0;
		end else if (clear) begin
			phase_q    <= spd_pkg::PH_SYNC;
			hc_q       <= 2'd0;
			acc_q      <= 24'd0;
			rem_q      <= 16'd0;
			esc_q      <= 1'b0;
			nonempty_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			hc_q       <= hc_d;
			acc_q      <= acc_d;
			rem_q      <= rem_d;
			esc_q      <= esc_d;
			nonempty_q <= nonempty_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		hc_d       = hc_q;
		acc_d      = acc_q;
		rem_d      = rem_q;
		esc_d      = esc_q;
		nonempty_d = nonempty_q;
		push       = '0;

		if (frame_mode == spd_pkg::MODE_LENGTH) begin
			if (phase_q == spd_pkg::PH_SYNC) begin
				if (hc_q != 2'd3) begin
					acc_d = len[23:0];
					hc_d  = hc_q + 2'd1;
				end else begin
					hc_d  = 2'd0;
					acc_d = 24'd0;
					// The whole 32-bit header is compared, so a set top bit fails too.
					if (len == 32'd0 || len > {16'd0, max_length}) begin
						push.count   = 2'd1;
						push.r0.lerr = 1'b1;
					end else begin
						rem_d   = len[15:0];
						phase_d = spd_pkg::PH_FRAME;
					end
				end
			end else begin
				rem_d          = rem_dec;
				push.count     = 2'd1;
				push.r0.data   = byte_s1;
				push.r0.valid  = 1'b1;
				push.r0.fend   = (rem_dec == 16'd0);
				if (rem_dec == 16'd0) begin
					phase_d = spd_pkg::PH_SYNC;
				end
			end
		end else begin
			if (phase_q == spd_pkg::PH_SYNC) begin
				// Hunting for the first END; everything before it is dropped.
				if (byte_s1 == spd_pkg::CHAR_END) begin
					phase_d    = spd_pkg::PH_FRAME;
					esc_d      = 1'b0;
					nonempty_d = 1'b0;
				end
			end else if (byte_s1 == spd_pkg::CHAR_END) begin
				// A pending escape is flushed as data ahead of the frame end.
				if (esc_q) begin
					push.count    = 2'd2;
					push.r0.data  = spd_pkg::CHAR_ESC;
					push.r0.valid = 1'b1;
					push.r1.fend  = 1'b1;
				end else if (nonempty_q) begin
					push.count    = 2'd1;
					push.r0.fend  = 1'b1;
				end
				esc_d      = 1'b0;
				nonempty_d = 1'b0;
			end else if (esc_q) begin
				nonempty_d    = 1'b1;
				push.count    = 2'd1;
				push.r0.valid = 1'b1;
				push.r0.data  = spd_pkg::CHAR_ESC;
				esc_d         = 1'b0;
				if (byte_s1 == spd_pkg::CHAR_ESC_END) begin
					push.r0.data = spd_pkg::CHAR_END;
				end else if (byte_s1 == spd_pkg::CHAR_ESC_ESC) begin
					push.r0.data = spd_pkg::CHAR_ESC;
				end else if (byte_s1 == spd_pkg::CHAR_ESC) begin
					// The second ESC stays pending.
					esc_d = 1'b1;
				end else begin
					// Unknown escape: both bytes go through untouched.
					push.count    = 2'd2;
					push.r1.data  = byte_s1;
					push.r1.valid = 1'b1;
				end
			end else if (byte_s1 == spd_pkg::CHAR_ESC) begin
				esc_d = 1'b1;
			end else begin
				push.count    = 2'd1;
				push.r0.data  = byte_s1;
				push.r0.valid = 1'b1;
				nonempty_d    = 1'b1;
			end
		end

		if (!step) begin
			push.count = 2'd0;
		end
	end

endmodule

`default_nettype wire

// File: design/spd_fifo.sv
`default_nettype none

module spd_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire spd_pkg::push_t        push,
	output spd_pkg::fifo_status_t      status,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output spd_pkg::result_t           head
);

	spd_pkg::result_t                  mem_q [spd_pkg::FIFO_DEPTH];
	logic [spd_pkg::PTR_W-1:0]         wr_ptr_q;
	logic [spd_pkg::PTR_W-1:0]         rd_ptr_q;
	logic [spd_pkg::LEVEL_W-1:0]       level_q;
	logic                              pop;
	logic [spd_pkg::PTR_W-1:0]         wr_ptr_p1;

	assign out_valid    = (level_q != '0);
	assign pop          = out_valid && !out_stall;
	assign head         = mem_q[rd_ptr_q];
	assign wr_ptr_p1    = wr_ptr_q + spd_pkg::PTR_W'(1);
	// Room for the worst case of two results, judged on the registered level only.
	assign status.room  = (level_q <= spd_pkg::LEVEL_W'(spd_pkg::FIFO_DEPTH - 2));
	assign status.level = level_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + spd_pkg::PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + spd_pkg::PTR_W'(1);
			end
			level_q <= level_q + spd_pkg::LEVEL_W'(push.count)
				- spd_pkg::LEVEL_W'(pop);
		end
	end

endmodule

`default_nettype wire

// File: design/stream_packet_deframer.sv
// Stream packet deframer. Received stream bytes enter one word per cycle on the
// in channel and recovered packet bytes leave on the out channel. With frame_mode
// 0 every packet is preceded by a four-byte big-endian length; a length of zero or
// above max_length yields a single word with length_error set, after which a fresh
// header is expected, and otherwise the body bytes are passed on with frame_end on
// the last. With frame_mode 1 the stream is SLIP: bytes before the first END are
// dropped, body bytes are unescaped, and an END closing a nonempty frame yields a
// word with byte_valid 0 and frame_end 1. A byte is taken into an input register
// and decoded from there into at most two result words, which go into a four-entry
// result queue once it has room for two; the first word is offered on the out
// channel in the cycle after its byte is decoded. The block accepts one byte every
// cycle as long as the queue is drained; a byte that yields two words (an unknown
// escape, or an escape just before END) takes longer to leave, as the out channel
// moves one word per cycle while out_stall is low. Writing frame_mode restarts
// framing from the header or the hunt for END; writing max_length affects only
// headers completed afterwards.

`default_nettype none

module stream_packet_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             frame_end,
	output logic             length_error
);

	logic                  frame_mode_q;
	logic [15:0]           max_length_q;
	logic                  clear;
	spd_pkg::push_t        push;
	spd_pkg::fifo_status_t status;
	spd_pkg::result_t      head;

	// Configuration registers. A write to frame_mode also clears the framing state.
	assign clear = cfg_we && (cfg_index == spd_pkg::CFG_FRAME_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= spd_pkg::MODE_LENGTH;
			max_length_q <= spd_pkg::MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spd_pkg::CFG_FRAME_MODE: frame_mode_q <= cfg_data[0];
				spd_pkg::CFG_MAX_LENGTH: max_length_q <= cfg_data;
				default:                 frame_mode_q <= frame_mode_q;
			endcase
		end
	end

	// Input register and the framing decoder.
	spd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.in_stall   (in_stall),
		.room       (status.room),
		.frame_mode (frame_mode_q),
		.max_length (max_length_q),
		.clear      (clear),
		.push       (push)
	);

	// Result queue that parts the decoder from the output handshake.
	spd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_byte     = head.data;
	assign byte_valid   = head.valid;
	assign frame_end    = head.fend;
	assign length_error = head.lerr;

	// The queue never holds more words than it has entries.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.level <= spd_pkg::LEVEL_W'(spd_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	// A length error word never carries packet data.
	a_lerr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> !byte_valid && !frame_end && out_byte == 8'd0)
		else $error("length error word carries data");

	// A frame end without data only comes from SLIP framing.
	a_bare_end_slip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end && !byte_valid |-> frame_mode_q == spd_pkg::MODE_SLIP
			&& out_byte == 8'd0)
		else $error("bare frame end outside SLIP mode");

	// Nothing is pushed into the queue while it lacks room for two words.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!status.room |-> push.count == 2'd0)
		else $error("push into a full result queue");

endmodule

`default_nettype wire

// File: tb/sv/deframer_monitor.sv
`default_nettype none

// Watches the configuration port and both word channels of the deframer, keeps
// its own copy of the framing state and compares every delivered word with the
// oldest one still expected.
module deframer_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,

	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  in_byte,

	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  out_byte,
	input  wire logic        byte_valid,
	input  wire logic        frame_end,
	input  wire logic        length_error,

	output int               mismatch_count,
	output int               words_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic             frame_mode;
	logic [15:0]      max_length;

	spd_pkg::phase_t  phase;
	logic [1:0]       header_count;
	logic [31:0]      length_accum;
	logic [15:0]      bytes_remaining;
	logic             escape_pending;
	logic             frame_nonempty;

	spd_pkg::result_t expected_words[$];
	spd_pkg::result_t oldest;

	function automatic void expect_word(input logic [7:0] data, input logic valid,
			input logic fend, input logic lerr);
		spd_pkg::result_t w;
		w.data  = data;
		w.valid = valid;
		w.fend  = fend;
		w.lerr  = lerr;
		expected_words.push_back(w);
	endfunction

	function automatic void restart_framing();
		phase           = spd_pkg::PH_SYNC;
		header_count    = 2'd0;
		length_accum    = 32'd0;
		bytes_remaining = 16'd0;
		escape_pending  = 1'b0;
		frame_nonempty  = 1'b0;
	endfunction

	function automatic void write_register(input logic idx, input logic [15:0] value);
		if (idx == spd_pkg::CFG_FRAME_MODE) begin
			frame_mode = value[0];
			restart_framing();
		end else begin
			max_length = value;
		end
	endfunction

	function automatic void decode_length(input logic [7:0] b);
		logic [31:0] len;
		if (phase == spd_pkg::PH_SYNC) begin
			length_accum = {length_accum[23:0], b};
			if (header_count != 2'd3) begin
				header_count = header_count + 2'd1;
			end else begin
				len          = length_accum;
				header_count = 2'd0;
				length_accum = 32'd0;
				if (len == 32'd0 || len > {16'd0, max_length}) begin
					expect_word(8'h00, 1'b0, 1'b0, 1'b1);
				end else begin
					bytes_remaining = len[15:0];
					phase           = spd_pkg::PH_FRAME;
				end
			end
		end else begin
			bytes_remaining = bytes_remaining - 16'd1;
			if (bytes_remaining == 16'd0) begin
				phase = spd_pkg::PH_SYNC;
				expect_word(b, 1'b1, 1'b1, 1'b0);
			end else begin
				expect_word(b, 1'b1, 1'b0, 1'b0);
			end
		end
	endfunction

	function automatic void decode_slip(input logic [7:0] b);
		if (phase == spd_pkg::PH_SYNC) begin
			if (b == spd_pkg::CHAR_END) begin
				phase          = spd_pkg::PH_FRAME;
				escape_pending = 1'b0;
				frame_nonempty = 1'b0;
			end
		end else if (b == spd_pkg::CHAR_END) begin
			// A dangling escape is flushed as data before the frame closes.
			if (escape_pending) begin
				expect_word(spd_pkg::CHAR_ESC, 1'b1, 1'b0, 1'b0);
				escape_pending = 1'b0;
				frame_nonempty = 1'b1;
			end
			if (frame_nonempty)
				expect_word(8'h00, 1'b0, 1'b1, 1'b0);
			frame_nonempty = 1'b0;
		end else if (escape_pending) begin
			if (b == spd_pkg::CHAR_ESC_END) begin
				expect_word(spd_pkg::CHAR_END, 1'b1, 1'b0, 1'b0);
				escape_pending = 1'b0;
			end else if (b == spd_pkg::CHAR_ESC_ESC) begin
				expect_word(spd_pkg::CHAR_ESC, 1'b1, 1'b0, 1'b0);
				escape_pending = 1'b0;
			end else if (b == spd_pkg::CHAR_ESC) begin
				expect_word(spd_pkg::CHAR_ESC, 1'b1, 1'b0, 1'b0);
			end else begin
				expect_word(spd_pkg::CHAR_ESC, 1'b1, 1'b0, 1'b0);
				expect_word(b, 1'b1, 1'b0, 1'b0);
				escape_pending = 1'b0;
			end
			frame_nonempty = 1'b1;
		end else if (b == spd_pkg::CHAR_ESC) begin
			escape_pending = 1'b1;
		end else begin
			expect_word(b, 1'b1, 1'b0, 1'b0);
			frame_nonempty = 1'b1;
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode = spd_pkg::MODE_LENGTH;
			max_length = spd_pkg::MAX_LENGTH_RESET;
			restart_framing();
			expected_words.delete();
			words_outstanding <= 0;
		end else begin
			if (cfg_we)
				write_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				if (frame_mode == spd_pkg::MODE_LENGTH)
					decode_length(in_byte);
				else
					decode_slip(in_byte);
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display({"%0t ns: expected no word, got out_byte %0h byte_valid %0b",
						" frame_end %0b length_error %0b"},
						$time, out_byte, byte_valid, frame_end, length_error);
					mismatch_count++;
				end else begin
					oldest = expected_words.pop_front();
					check_field("out_byte", oldest.data, out_byte);
					check_field("byte_valid", {7'd0, oldest.valid}, {7'd0, byte_valid});
					check_field("frame_end", {7'd0, oldest.fend}, {7'd0, frame_end});
					check_field("length_error", {7'd0, oldest.lerr}, {7'd0, length_error});
				end
			end
			words_outstanding <= expected_words.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

// Top level of the deframer bench. It generates the clock and the single reset,
// drives the configuration port and the input word channel, stalls the output
// channel, and gives the verdict. All prediction and comparison happens in the
// monitor instantiated beside the block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// A generous ceiling on the run; the slowest legitimate run needs a small
	// fraction of this even with every word waiting out the longest stall.
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          LONG_HOLD   = 300;
	localparam int          PHASE_BYTES = 190;
	localparam int          NUM_PHASES  = 8;
	// Cycles to let the block finish a byte that yields no word before a
	// register is written or the run is ended.
	localparam int          DRAIN_WAIT  = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = spd_pkg::CFG_FRAME_MODE;
	logic [15:0] cfg_data  = 16'd0;
	logic        in_valid  = 1'b0;
	logic [7:0]  in_byte   = 8'd0;
	logic        out_stall = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        frame_end;
	logic        length_error;

	int          mismatch_count;
	int          words_outstanding;

	int unsigned cycle_count = 0;
	int          burst_left  = 0;
	int          items_sent  = 0;
	// Long holds asked for by the stimulus and those already begun by the receiver.
	int          holds_asked = 0;
	int          holds_taken = 0;
	int          hold_left   = 0;
	int          stall_style;
	int          span;
	int          k;
	int          p;
	int          target;

	// The stimulus keeps its own note of the settings, purely to shape the
	// packets it builds; the monitor predicts independently.
	logic        cur_mode = spd_pkg::MODE_LENGTH;
	logic [15:0] cur_max  = spd_pkg::MAX_LENGTH_RESET;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stream_packet_deframer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.frame_end   (frame_end),
		.length_error(length_error)
	);

	deframer_monitor i_monitor (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_byte         (out_byte),
		.byte_valid       (byte_valid),
		.frame_end        (frame_end),
		.length_error     (length_error),
		.mismatch_count   (mismatch_count),
		.words_outstanding(words_outstanding)
	);

	// Watchdog: a hung handshake or a lost word ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver. It changes its stall style every so often, including stretches
	// with no stall at all. When the stimulus asks for it, it holds off for a
	// long stretch so that the result queue fills and the input is stalled.
	initial begin
		forever begin
			stall_style = $urandom_range(0, 4);
			span        = $urandom_range(16, 160);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				if (holds_taken != holds_asked) begin
					holds_taken = holds_asked;
					hold_left   = LONG_HOLD;
				end
				if (hold_left != 0) begin
					hold_left--;
					out_stall <= 1'b1;
				end else begin
					case (stall_style)
						0:       out_stall <= 1'b0;
						1:       out_stall <= ($urandom_range(0, 3) == 0);
						2:       out_stall <= ($urandom_range(0, 3) != 0);
						3:       out_stall <= ((k % 5) < 2);
						default: out_stall <= ((k % 16) >= 10);
					endcase
				end
			end
		end
	end

	// Offers one word and returns just after the edge at which it is taken.
	// The sender works in bursts; between bursts it may drop valid for a random gap.
	// Valid is only lowered when a gap really follows, so it is never lowered and
	// raised within the same time step.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Big-endian length header of a length-prefixed packet.
	task automatic send_header(input logic [31:0] len);
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// The idle cycle after a register write keeps the write enable from being
	// lowered and raised in the same time step.
	task automatic write_reg(input logic idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == spd_pkg::CFG_FRAME_MODE)
			cur_mode = value[0];
		else
			cur_max = value;
		@(posedge clk);
	endtask

	// Stops offering words and waits until every expected word has been
	// delivered, then waits on so that a byte that yields no word is finished too.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (words_outstanding != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Mostly well-formed packets with short random bodies; now and then a
	// header that must be refused: zero, one above the limit, the top bit set,
	// or entirely random.
	task automatic send_length_packet();
		logic [31:0] len;
		int          pick;
		pick = $urandom_range(0, 19);
		if (cur_max != 16'd0 && pick < 17) begin
			len = $urandom_range(1, (cur_max > 16'd48) ? 48 : int'(cur_max));
			if (pick == 0 && cur_max <= 16'd300)
				len = {16'd0, cur_max};
		end else begin
			case (pick % 4)
				0:       len = 32'd0;
				1:       len = {16'd0, cur_max} + 32'd1;
				2:       len = {1'b1, 31'($urandom)};
				default: len = $urandom;
			endcase
		end
		send_header(len);
		if (len != 32'd0 && len <= {16'd0, cur_max}) begin
			repeat (len) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// A SLIP frame closed by END, with escapes of every kind mixed into the
	// body. Sometimes the frame is empty, sometimes an escape sits right
	// before END, and sometimes raw noise is sent instead.
	task automatic send_slip_frame();
		int         n;
		int         pick;
		logic [7:0] b;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 20);
			repeat (n) begin
				pick = $urandom_range(0, 15);
				case (pick)
					0: begin
						send_byte(spd_pkg::CHAR_ESC);
						send_byte(spd_pkg::CHAR_ESC_END);
					end
					1: begin
						send_byte(spd_pkg::CHAR_ESC);
						send_byte(spd_pkg::CHAR_ESC_ESC);
					end
					2: begin
						send_byte(spd_pkg::CHAR_ESC);
						send_byte(8'($urandom_range(0, 255)));
					end
					default: begin
						b = 8'($urandom_range(0, 255));
						if (b == spd_pkg::CHAR_END || b == spd_pkg::CHAR_ESC)
							b = b ^ 8'h01;
						send_byte(b);
					end
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				send_byte(spd_pkg::CHAR_ESC);
			send_byte(spd_pkg::CHAR_END);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed words in length mode at the reset settings: the shortest
		// body, a zero length, and a length with the top bit set.
		send_header(32'h0000_0001);
		send_byte(8'hff);
		send_header(32'h0000_0000);
		send_header(32'h8000_0005);

		// Directed words in SLIP mode: a byte before the first END, an empty
		// frame, both escape codes, an escape followed by another escape, an
		// unknown escape, and an escape directly before END.
		settle();
		write_reg(spd_pkg::CFG_FRAME_MODE, {15'd0, spd_pkg::MODE_SLIP});
		send_byte(8'h55);
		send_byte(spd_pkg::CHAR_END);
		send_byte(spd_pkg::CHAR_END);
		send_byte(8'h00);
		send_byte(spd_pkg::CHAR_ESC);
		send_byte(spd_pkg::CHAR_ESC_END);
		send_byte(spd_pkg::CHAR_ESC);
		send_byte(spd_pkg::CHAR_ESC_ESC);
		send_byte(spd_pkg::CHAR_ESC);
		send_byte(spd_pkg::CHAR_ESC);
		send_byte(spd_pkg::CHAR_ESC_ESC);
		send_byte(spd_pkg::CHAR_ESC);
		send_byte(8'h41);
		send_byte(8'hff);
		send_byte(spd_pkg::CHAR_ESC);
		send_byte(spd_pkg::CHAR_END);

		// Random phases, each under its own settings. Some phases only change
		// max_length, so framing carries on from where the last phase left off;
		// a partly sent body then finishes under the new limit.
		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: begin
					write_reg(spd_pkg::CFG_FRAME_MODE, {15'd0, spd_pkg::MODE_LENGTH});
					write_reg(spd_pkg::CFG_MAX_LENGTH, 16'd1);
				end
				1: begin
					write_reg(spd_pkg::CFG_FRAME_MODE, {15'd0, spd_pkg::MODE_SLIP});
					write_reg(spd_pkg::CFG_MAX_LENGTH, 16'd300);
				end
				2: begin
					write_reg(spd_pkg::CFG_FRAME_MODE, {15'd0, spd_pkg::MODE_LENGTH});
					write_reg(spd_pkg::CFG_MAX_LENGTH, 16'hffff);
				end
				3: write_reg(spd_pkg::CFG_MAX_LENGTH, 16'd0);
				4: write_reg(spd_pkg::CFG_FRAME_MODE, {15'd0, spd_pkg::MODE_SLIP});
				5: begin
					write_reg(spd_pkg::CFG_FRAME_MODE, {15'd0, spd_pkg::MODE_LENGTH});
					write_reg(spd_pkg::CFG_MAX_LENGTH, 16'($urandom_range(2, 40)));
				end
				6: write_reg(spd_pkg::CFG_MAX_LENGTH, 16'($urandom_range(1, 40)));
				default: write_reg(spd_pkg::CFG_FRAME_MODE, {15'd0, spd_pkg::MODE_SLIP});
			endcase
			if (p % 2 == 0)
				holds_asked++;
			target = items_sent + PHASE_BYTES;
			while (items_sent < target) begin
				if (cur_mode == spd_pkg::MODE_LENGTH)
					send_length_packet();
				else
					send_slip_frame();
			end
			// Leave a body half sent so that the next phase picks it up.
			if (cur_mode == spd_pkg::MODE_LENGTH
					&& (p == 2 || $urandom_range(0, 1) == 1)) begin
				send_header(32'h0000_0008);
				repeat (3) send_byte(8'($urandom_range(0, 255)));
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && words_outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
design/spd_pkg.sv
design/spd_core.sv
design/spd_fifo.sv
design/stream_packet_deframer.sv
tb/sv/deframer_monitor.sv
tb/sv/testbench.sv
